### src/pfa_pkg.sv
`default_nettype none
package pfa_pkg;

    localparam int NUM_FRAMES = 32768;
    localparam int PAGE_SHIFT = 12;

    localparam int ADDR_W  = 27;
    localparam int FNUM_W  = ADDR_W - PAGE_SHIFT;
    localparam int FRAME_W = $clog2(NUM_FRAMES);
    localparam int CNT_W   = 7;
    localparam int DEPTH_W = 16;
    localparam int SETV_W  = 8;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 2;

    localparam logic [CNT_W-1:0] REF_MAX = CNT_W'(64);

    typedef logic [2:0] t_mode;
    typedef logic [2:0] t_status;

    localparam t_mode MODE_ALLOC = 3'd0;
    localparam t_mode MODE_FREE  = 3'd1;
    localparam t_mode MODE_INC   = 3'd2;
    localparam t_mode MODE_DEC   = 3'd3;
    localparam t_mode MODE_SET   = 3'd4;
    localparam t_mode MODE_QUERY = 3'd5;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_BAD_ADDR  = 3'd1;
    localparam t_status ST_SHARED    = 3'd2;
    localparam t_status ST_OVERFLOW  = 3'd3;
    localparam t_status ST_UNDERFLOW = 3'd4;
    localparam t_status ST_SET_BIG   = 3'd5;
    localparam t_status ST_OOM       = 3'd6;
    localparam t_status ST_FULL      = 3'd7;

    localparam logic [PADDR_W-1:0] REG_FIRST_FREE = PADDR_W'(0);

endpackage
`default_nettype wire

### src/page_frame_allocator_refcount_top.sv
// Page-frame allocator with per-frame reference counts.
//
// Request channel: a request word (i_mode, i_address, i_set_value) is taken at
// a rising edge with start high and busy low. Each request gives exactly one
// result word on o_status, o_frame_address, o_ref_count and o_free_count,
// shown for one cycle with o_valid high; the receiver cannot stall it.
//
// Execution: o_valid and the result word are registered as the request leaves
// the execute state. busy is high for the one cycle in which the count and
// stack memories, read at the accepting edge, are modified and written back,
// so no new request is taken until that read-modify-write pass over the RAMs
// is done.
//
// Configuration: APB write of first_free_frame at byte address 0; pready is
// always high, prdata returns the register.
//
// Reset: the reference count memory is cleared one entry a cycle, with busy
// high; configuration writes are still taken.
`default_nettype none
module page_frame_allocator_refcount_top (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire  pfa_pkg::t_mode               i_mode,
    input  wire  [pfa_pkg::ADDR_W-1:0]         i_address,
    input  wire  [pfa_pkg::SETV_W-1:0]         i_set_value,
    output logic                               o_valid,
    output pfa_pkg::t_status                   o_status,
    output logic [pfa_pkg::ADDR_W-1:0]         o_frame_address,
    output logic [pfa_pkg::CNT_W-1:0]          o_ref_count,
    output logic [pfa_pkg::DEPTH_W-1:0]        o_free_count,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [pfa_pkg::PADDR_W-1:0]        paddr,
    input  wire  [pfa_pkg::DATA_W-1:0]         pwdata,
    output logic [pfa_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);
    import pfa_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_CLEAR = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [FRAME_W-1:0]  r_clr;
    logic [DEPTH_W-1:0]  r_depth, n_depth;
    logic [DEPTH_W-1:0]  r_fresh, n_fresh;
    logic [DEPTH_W-1:0]  r_fff;

    t_mode               r_mode;
    logic [ADDR_W-1:0]   r_addr;
    logic [SETV_W-1:0]   r_setv;

    logic [CNT_W-1:0]    cnt_mem [NUM_FRAMES];
    logic [FRAME_W-1:0]  stk_mem [NUM_FRAMES];
    logic [CNT_W-1:0]    cnt_q;
    logic [FRAME_W-1:0]  stk_q;

    logic                accept;
    logic [FNUM_W-1:0]   in_frame;
    logic [FRAME_W-1:0]  cnt_raddr, stk_raddr;
    logic [DEPTH_W-1:0]  depth_m1;

    logic                cnt_we, ex_cnt_we;
    logic [FRAME_W-1:0]  cnt_waddr, ex_cnt_waddr;
    logic [CNT_W-1:0]    cnt_wdata, ex_cnt_wdata;
    logic                stk_we;
    logic [FRAME_W-1:0]  stk_waddr, stk_wdata;

    t_status             ex_status;
    logic [ADDR_W-1:0]   ex_faddr;
    logic [CNT_W-1:0]    ex_ref;
    logic [DEPTH_W-1:0]  ex_free;

    logic                cfg_we;

    assign accept    = start && (r_state == S_IDLE);
    assign busy      = (r_state != S_IDLE);
    assign in_frame  = i_address[ADDR_W-1:PAGE_SHIFT];
    assign cnt_raddr = in_frame[FRAME_W-1:0];
    assign depth_m1  = r_depth - DEPTH_W'(1);
    assign stk_raddr = depth_m1[FRAME_W-1:0];

    assign cfg_we = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr == REG_FIRST_FREE) ? DATA_W'(r_fff) : '0;

    always_comb begin
        logic [FNUM_W-1:0]  frame;
        logic [FRAME_W-1:0] fidx;
        logic [FRAME_W-1:0] f;
        logic [DEPTH_W-1:0] fresh_m1;
        logic [DEPTH_W-1:0] avail;
        logic [DEPTH_W:0]   sum;
        logic               in_range;
        logic [CNT_W-1:0]   c;

        frame    = r_addr[ADDR_W-1:PAGE_SHIFT];
        fidx     = frame[FRAME_W-1:0];
        fresh_m1 = r_fresh - DEPTH_W'(1);
        in_range = (32'(frame) < 32'(NUM_FRAMES));
        c        = cnt_q;
        f        = '0;

        n_depth      = r_depth;
        n_fresh      = r_fresh;
        ex_status    = ST_OK;
        ex_faddr     = '0;
        ex_ref       = '0;
        ex_cnt_we    = 1'b0;
        ex_cnt_waddr = fidx;
        ex_cnt_wdata = '0;
        stk_we       = 1'b0;
        stk_waddr    = r_depth[FRAME_W-1:0];
        stk_wdata    = fidx;

        if (r_mode == MODE_ALLOC) begin
            if (r_depth != '0) begin
                n_depth = depth_m1;
                f       = stk_q;
            end else if (r_fresh > r_fff) begin
                n_fresh = fresh_m1;
                f       = fresh_m1[FRAME_W-1:0];
            end else begin
                ex_status = ST_OOM;
            end
            if (ex_status == ST_OK) begin
                ex_cnt_we    = 1'b1;
                ex_cnt_waddr = f;
                ex_cnt_wdata = CNT_W'(1);
                ex_faddr     = ADDR_W'({f, {PAGE_SHIFT{1'b0}}});
                ex_ref       = CNT_W'(1);
            end
        end else if (r_mode <= MODE_QUERY) begin
            ex_faddr = {frame, {PAGE_SHIFT{1'b0}}};
            if (!in_range) begin
                ex_status = ST_BAD_ADDR;
            end else begin
                case (r_mode)
                    MODE_FREE: begin
                        if (r_addr[PAGE_SHIFT-1:0] != '0 || DEPTH_W'(frame) < r_fff) begin
                            ex_status = ST_BAD_ADDR;
                        end else if (c > CNT_W'(1)) begin
                            ex_status = ST_SHARED;
                        end else if (r_depth >= DEPTH_W'(NUM_FRAMES)) begin
                            ex_status = ST_FULL;
                        end else begin
                            stk_we  = 1'b1;
                            n_depth = r_depth + DEPTH_W'(1);
                            c       = '0;
                        end
                    end
                    MODE_INC: begin
                        if (c >= REF_MAX) ex_status = ST_OVERFLOW;
                        else c = c + CNT_W'(1);
                    end
                    MODE_DEC: begin
                        if (c == '0) ex_status = ST_UNDERFLOW;
                        else c = c - CNT_W'(1);
                    end
                    MODE_SET: begin
                        if (r_setv > SETV_W'(REF_MAX)) ex_status = ST_SET_BIG;
                        else c = r_setv[CNT_W-1:0];
                    end
                    default: ;
                endcase
                ex_cnt_we    = 1'b1;
                ex_cnt_wdata = c;
                ex_ref       = c;
            end
        end

        avail   = (n_fresh > r_fff) ? (n_fresh - r_fff) : '0;
        sum     = {1'b0, n_depth} + {1'b0, avail};
        ex_free = sum[DEPTH_W] ? '1 : sum[DEPTH_W-1:0];
    end

    always_comb begin
        n_state   = r_state;
        cnt_we    = 1'b0;
        cnt_waddr = ex_cnt_waddr;
        cnt_wdata = ex_cnt_wdata;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_EXEC;
            end
            S_EXEC: begin
                cnt_we  = ex_cnt_we;
                n_state = S_IDLE;
            end
            S_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_clr;
                cnt_wdata = '0;
                if (r_clr == '1) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
        cnt_q <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we && r_state == S_EXEC) stk_mem[stk_waddr] <= stk_wdata;
        stk_q <= stk_mem[stk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_mode;
            r_addr <= i_address;
            r_setv <= i_set_value;
        end
        o_status        <= ex_status;
        o_frame_address <= ex_faddr;
        o_ref_count     <= ex_ref;
        o_free_count    <= ex_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_depth <= '0;
            r_fresh <= DEPTH_W'(NUM_FRAMES);
            r_fff   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= (r_state == S_EXEC);
            if (r_state == S_CLEAR) r_clr <= r_clr + FRAME_W'(1);
            if (r_state == S_EXEC) begin
                r_depth <= n_depth;
                r_fresh <= n_fresh;
            end
            if (cfg_we && paddr == REG_FIRST_FREE) r_fff <= pwdata[DEPTH_W-1:0];
        end
    end

endmodule
`default_nettype wire

### src/pfa_checker.sv
`default_nettype none
module pfa_checker (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         start,
    input wire                         busy,
    input wire                         o_valid,
    input wire pfa_pkg::t_status       o_status,
    input wire [pfa_pkg::ADDR_W-1:0]   o_frame_address,
    input wire [pfa_pkg::CNT_W-1:0]    o_ref_count
);
    import pfa_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted word");

    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("no result two cycles after accepted word");

    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a request in flight");

    a_oom_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OOM) |-> (o_frame_address == '0 && o_ref_count == '0))
        else $error("out of memory result carries a frame");

    a_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_address[PAGE_SHIFT-1:0] == '0 && o_ref_count <= REF_MAX))
        else $error("unaligned frame address or count above limit");

endmodule

bind page_frame_allocator_refcount_top pfa_checker u_pfa_checker (.*);
`default_nettype wire

### verif/page_frame_allocator_refcount_top_tb.sv
`timescale 1ns / 100ps
module page_frame_allocator_refcount_top_tb;
    import pfa_pkg::*;

    localparam t_mode MODE_RSVD6 = 3'd6;
    localparam t_mode MODE_RSVD7 = 3'd7;
    localparam int unsigned STALL_LIMIT = 150000;
    localparam int unsigned PHASE_WORDS = 450;
    localparam int unsigned LIVE_MAX = 24;

    typedef struct packed {
        t_status                status;
        logic [ADDR_W-1:0]      frame_address;
        logic [CNT_W-1:0]       ref_count;
        logic [DEPTH_W-1:0]     free_count;
    } t_alloc_result;

    typedef struct {
        bit                     is_cfg;
        int unsigned            cfg_value;
        t_mode                  mode;
        logic [ADDR_W-1:0]      address;
        logic [SETV_W-1:0]      set_value;
        bit                     typed;
        t_alloc_result          want;
    } t_dir_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    t_mode                  i_mode;
    logic [ADDR_W-1:0]      i_address;
    logic [SETV_W-1:0]      i_set_value;
    logic                   o_valid;
    t_status                o_status;
    logic [ADDR_W-1:0]      o_frame_address;
    logic [CNT_W-1:0]       o_ref_count;
    logic [DEPTH_W-1:0]     o_free_count;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]      pwdata;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    page_frame_allocator_refcount_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_address       (i_address),
        .i_set_value     (i_set_value),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_frame_address (o_frame_address),
        .o_ref_count     (o_ref_count),
        .o_free_count    (o_free_count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #1 i_clk = ~i_clk;

    // allocator shadow state
    logic [CNT_W-1:0]       page_refs [NUM_FRAMES];
    logic [FRAME_W-1:0]     free_stack [NUM_FRAMES];
    int unsigned            pushed_count;
    int unsigned            untouched_top;
    int unsigned            first_managed;

    t_alloc_result          pending_results [$];
    t_dir_row               dir_rows [$];
    int unsigned            live_frames [$];
    int unsigned            mismatch_count = 0;
    int unsigned            stall_cycles = 0;

    function automatic t_alloc_result allocator_step(input t_mode m,
                                                     input logic [ADDR_W-1:0] a,
                                                     input logic [SETV_W-1:0] s);
        t_alloc_result  r;
        int unsigned    frame;
        int unsigned    f;
        int unsigned    avail;
        logic [CNT_W-1:0] c;
        bit             got;
        r = '0;
        frame = int'(a >> PAGE_SHIFT);
        f = 0;
        got = 1'b0;
        if (m == MODE_ALLOC) begin
            if (pushed_count > 0) begin
                pushed_count--;
                f = free_stack[pushed_count];
                got = 1'b1;
            end else if (untouched_top > first_managed) begin
                untouched_top--;
                f = untouched_top;
                got = 1'b1;
            end
            if (got) begin
                page_refs[f] = CNT_W'(1);
                r.frame_address = ADDR_W'(f << PAGE_SHIFT);
                r.ref_count = CNT_W'(1);
            end else begin
                r.status = ST_OOM;
            end
        end else if (m <= MODE_QUERY) begin
            r.frame_address = ADDR_W'(frame << PAGE_SHIFT);
            if (frame >= NUM_FRAMES) begin
                r.status = ST_BAD_ADDR;
            end else begin
                c = page_refs[frame];
                case (m)
                    MODE_FREE: begin
                        if (a[PAGE_SHIFT-1:0] != '0 || frame < first_managed)
                            r.status = ST_BAD_ADDR;
                        else if (c > 1)
                            r.status = ST_SHARED;
                        else if (pushed_count >= NUM_FRAMES)
                            r.status = ST_FULL;
                        else begin
                            free_stack[pushed_count] = FRAME_W'(frame);
                            pushed_count++;
                            c = '0;
                        end
                    end
                    MODE_INC: begin
                        if (c >= REF_MAX) r.status = ST_OVERFLOW;
                        else c = c + 1'b1;
                    end
                    MODE_DEC: begin
                        if (c == '0) r.status = ST_UNDERFLOW;
                        else c = c - 1'b1;
                    end
                    MODE_SET: begin
                        if (s > REF_MAX) r.status = ST_SET_BIG;
                        else c = CNT_W'(s);
                    end
                    default: ;
                endcase
                page_refs[frame] = c;
                r.ref_count = c;
            end
        end
        avail = pushed_count + ((untouched_top > first_managed) ?
                                untouched_top - first_managed : 0);
        r.free_count = (avail > 65535) ? '1 : DEPTH_W'(avail);
        return r;
    endfunction

    task automatic submit_request(input t_mode m, input logic [ADDR_W-1:0] a,
                                  input logic [SETV_W-1:0] s, input bit may_idle,
                                  input bit typed, input t_alloc_result want,
                                  output t_alloc_result got);
        while (may_idle && $urandom_range(99) < 17) begin
            start <= 1'b0;
            i_mode <= t_mode'($urandom);
            i_address <= ADDR_W'($urandom);
            i_set_value <= SETV_W'($urandom);
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_mode <= m;
        i_address <= a;
        i_set_value <= s;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        got = allocator_step(m, a, s);
        pending_results.push_back(typed ? want : got);
    endtask

    // drop start and let every outstanding word come back
    task automatic settle;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_first_free(input int unsigned value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_FIRST_FREE;
        pwdata <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        first_managed = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        if (prdata !== DATA_W'(value)) begin
            if (mismatch_count < 10)
                $display("readback first_free: exp %0d got %0d", value, prdata);
            mismatch_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic add_row(input bit is_cfg, input int unsigned cfg_value, input t_mode m,
                           input logic [ADDR_W-1:0] a, input logic [SETV_W-1:0] s,
                           input bit typed, input t_status st,
                           input logic [ADDR_W-1:0] fa, input logic [CNT_W-1:0] rc,
                           input logic [DEPTH_W-1:0] fc);
        t_dir_row row;
        row.is_cfg = is_cfg;
        row.cfg_value = cfg_value;
        row.mode = m;
        row.address = a;
        row.set_value = s;
        row.typed = typed;
        row.want = '{status: st, frame_address: fa, ref_count: rc, free_count: fc};
        dir_rows.push_back(row);
    endtask

    task automatic random_request(input bit may_idle);
        int unsigned    pick;
        int unsigned    frame;
        t_mode          m;
        logic [ADDR_W-1:0] a;
        logic [PAGE_SHIFT-1:0] low;
        logic [SETV_W-1:0] s;
        t_alloc_result  got;
        pick = $urandom_range(99);
        if (pick < 25)      m = MODE_ALLOC;
        else if (pick < 45) m = MODE_FREE;
        else if (pick < 60) m = MODE_INC;
        else if (pick < 75) m = MODE_DEC;
        else if (pick < 85) m = MODE_SET;
        else if (pick < 95) m = MODE_QUERY;
        else                m = ($urandom_range(1) != 0) ? MODE_RSVD6 : MODE_RSVD7;
        a = ADDR_W'($urandom);
        if (live_frames.size() != 0 && $urandom_range(99) < 80) begin
            frame = live_frames[$urandom_range(live_frames.size() - 1)];
            low = (m == MODE_FREE && $urandom_range(9) != 0) ? '0 : a[PAGE_SHIFT-1:0];
            a = {frame[FNUM_W-1:0], low};
        end
        s = ($urandom_range(99) < 80) ? SETV_W'($urandom_range(64)) : SETV_W'($urandom);
        submit_request(m, a, s, may_idle, 1'b0, '0, got);
        if (m == MODE_ALLOC && got.status == ST_OK) begin
            live_frames.push_back(int'(got.frame_address >> PAGE_SHIFT));
            if (live_frames.size() > LIVE_MAX) void'(live_frames.pop_front());
        end
    endtask

    always @(posedge i_clk) begin
        t_alloc_result seen;
        t_alloc_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            seen = {o_status, o_frame_address, o_ref_count, o_free_count};
            if (pending_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected word: st %0d addr %h ref %0d free %0d",
                             o_status, o_frame_address, o_ref_count, o_free_count);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (seen !== want) begin
                    if (mismatch_count < 10)
                        $display("mismatch: exp %0d %h %0d %0d, got %0d %h %0d %0d",
                                 want.status, want.frame_address, want.ref_count,
                                 want.free_count, o_status, o_frame_address,
                                 o_ref_count, o_free_count);
                    mismatch_count++;
                end
            end
        end
    end

    // stall watchdog
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("page_frame_allocator_refcount_top_tb: errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_alloc_result got;
        t_dir_row      row;
        int unsigned   cfg;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_mode <= MODE_ALLOC;
        i_address <= '0;
        i_set_value <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= REG_FIRST_FREE;
        pwdata <= '0;
        foreach (page_refs[k]) page_refs[k] = '0;
        foreach (free_stack[k]) free_stack[k] = '0;
        pushed_count = 0;
        untouched_top = NUM_FRAMES;
        first_managed = 0;

        add_row(0, 0, MODE_QUERY, 27'h0, 8'h0, 1, ST_OK, 27'h0, 7'd0, 16'd32768);
        add_row(0, 0, MODE_ALLOC, 27'h0, 8'h0, 1, ST_OK, 27'h7FFF000, 7'd1, 16'd32767);
        add_row(0, 0, MODE_INC, 27'h7FFF000, 8'h0, 0, ST_OK, '0, '0, '0);
        add_row(0, 0, MODE_FREE, 27'h7FFF000, 8'h0, 1, ST_SHARED, 27'h7FFF000, 7'd2,
                16'd32767);
        add_row(0, 0, MODE_DEC, 27'h7FFF000, 8'h0, 0, ST_OK, '0, '0, '0);
        add_row(0, 0, MODE_FREE, 27'h7FFF000, 8'h0, 0, ST_OK, '0, '0, '0);
        add_row(0, 0, MODE_DEC, 27'h7FFF000, 8'h0, 1, ST_UNDERFLOW, 27'h7FFF000, 7'd0,
                16'd32768);
        // double free goes undetected
        add_row(0, 0, MODE_FREE, 27'h7FFF000, 8'h0, 0, ST_OK, '0, '0, '0);
        add_row(0, 0, MODE_ALLOC, 27'h0, 8'h0, 0, ST_OK, '0, '0, '0);
        add_row(0, 0, MODE_ALLOC, 27'h0, 8'h0, 0, ST_OK, '0, '0, '0);
        add_row(0, 0, MODE_SET, 27'h7FFF000, 8'd64, 0, ST_OK, '0, '0, '0);
        add_row(0, 0, MODE_INC, 27'h7FFF000, 8'h0, 1, ST_OVERFLOW, 27'h7FFF000, 7'd64,
                16'd32767);
        add_row(0, 0, MODE_SET, 27'h7FFF000, 8'd65, 1, ST_SET_BIG, 27'h7FFF000, 7'd64,
                16'd32767);
        add_row(0, 0, MODE_SET, 27'h7FFF000, 8'hFF, 0, ST_OK, '0, '0, '0);
        add_row(0, 0, MODE_SET, 27'h7FFF800, 8'd0, 0, ST_OK, '0, '0, '0);
        add_row(0, 0, MODE_FREE, 27'h7FFF001, 8'h0, 0, ST_OK, '0, '0, '0);
        add_row(0, 0, MODE_QUERY, 27'h7FFFFFF, 8'hFF, 0, ST_OK, '0, '0, '0);
        add_row(0, 0, MODE_RSVD6, 27'h0, 8'h0, 1, ST_OK, 27'h0, 7'd0, 16'd32767);
        add_row(0, 0, MODE_RSVD7, 27'h7FFFFFF, 8'hFF, 0, ST_OK, '0, '0, '0);
        add_row(0, 0, MODE_FREE, 27'h0, 8'h0, 0, ST_OK, '0, '0, '0);
        add_row(0, 0, MODE_ALLOC, 27'h0, 8'h0, 0, ST_OK, '0, '0, '0);
        add_row(1, NUM_FRAMES, MODE_ALLOC, '0, '0, 0, ST_OK, '0, '0, '0);
        add_row(0, 0, MODE_FREE, 27'h7FFF000, 8'h0, 0, ST_OK, '0, '0, '0);
        add_row(0, 0, MODE_ALLOC, 27'h5A5A5A5, 8'hA5, 1, ST_OOM, 27'h0, 7'd0, 16'd0);
        add_row(0, 0, MODE_QUERY, 27'h0, 8'h0, 0, ST_OK, '0, '0, '0);
        add_row(1, 0, MODE_ALLOC, '0, '0, 0, ST_OK, '0, '0, '0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            if (row.is_cfg) begin
                settle();
                write_first_free(row.cfg_value);
            end else begin
                submit_request(row.mode, row.address, row.set_value, 1'b1, row.typed,
                               row.want, got);
            end
        end

        // near-exhausted pool, random, all kernel, none kernel
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: cfg = (untouched_top > 12) ? untouched_top - 12 : 0;
                1: cfg = $urandom_range(NUM_FRAMES);
                2: cfg = NUM_FRAMES;
                default: cfg = 0;
            endcase
            settle();
            write_first_free(cfg);
            for (int i = 0; i < PHASE_WORDS; i++)
                random_request(!(p == 1 && i >= 100 && i < 400));
        end

        // push one frame several times back to back, then pop it back out
        submit_request(MODE_SET, 27'h0, 8'd0, 1'b1, 1'b0, '0, got);
        repeat (3)
            submit_request(MODE_FREE, 27'h0, 8'h0, 1'b0, 1'b0, '0, got);
        submit_request(MODE_FREE, 27'h0, 8'h0, 1'b1, 1'b0, '0, got);
        for (int i = 0; i < 4; i++)
            submit_request(MODE_ALLOC, 27'h0, 8'h0, 1'b1, 1'b0, '0, got);
        submit_request(MODE_QUERY, 27'h0, 8'h0, 1'b1, 1'b0, '0, got);

        settle();
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0) mismatch_count++;
        if (mismatch_count == 0) begin
            $display("page_frame_allocator_refcount_top_tb: clean");
        end else begin
            $display("page_frame_allocator_refcount_top_tb: errors");
        end
        $finish;
    end

endmodule
